// ----- rtl/hsa_pkg.sv -----
// ----------------------------------------------------------------------------
// hsa_pkg
// shared types and constants of the handle slot allocator
// ----------------------------------------------------------------------------
`default_nettype none

package hsa_pkg;

  // table geometry
  localparam int unsigned TableEntries = 4096;
  localparam int unsigned SlotW        = 12;
  localparam int unsigned CountW       = 13;

  localparam logic [CountW-1:0] TABLE_ENTRIES = CountW'(TableEntries);

  // request opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // response status codes
  localparam logic [1:0] ST_ALLOCATED = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_FREED     = 2'd2;

  typedef struct packed {
    logic             opcode;
    logic [SlotW-1:0] slot_to_free;
  } req_t;

  typedef struct packed {
    logic [SlotW-1:0]  slot_given;
    logic [1:0]        status;
    logic [CountW-1:0] high_water;
    logic [CountW-1:0] free_slots;
  } rsp_t;

endpackage

`default_nettype wire

// ----- rtl/handle_slot_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// handle_slot_allocator_unit
// slot allocator: lifo free list threaded through a link memory, with a
// bump pointer for never-used slots and a free-slot count
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload          | direction
//  ---------+----------------------+------------------+----------
//  request  | req_valid/req_ready  | req (req_t)      | in
//  response | rsp_valid/rsp_ready  | rsp (rsp_t)      | out
//
//  a free, a bump allocate and a full reply load the response at the accept
//  a pop from the free list goes on through S_POP, where no request is taken:
//  the link of the head slot is read from the synchronous link memory at the accept
//  one response register sits on the output; a request is taken while the
//  register is empty or the held response is being taken in the same cycle
//  rst is synchronous: list empty, bump pointer zero, every slot free;
//  no request is taken while rst is high
//  the link memory is not cleared, only links written by a free are read
// ----------------------------------------------------------------------------
`default_nettype none

module handle_slot_allocator_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire hsa_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output hsa_pkg::rsp_t      rsp
);

  typedef enum logic {
    S_IDLE,
    S_POP
  } state_t;

  state_t state;

  // allocator state
  logic [hsa_pkg::CountW-1:0] list_head;
  logic [hsa_pkg::CountW-1:0] bump_pointer;
  logic [hsa_pkg::CountW-1:0] free_count;

  // link memory, one next-link per slot
  logic [hsa_pkg::CountW-1:0] link_mem [hsa_pkg::TableEntries];
  logic [hsa_pkg::CountW-1:0] link_rd;
  logic                       link_we;

  logic req_fire;
  logic out_free;
  logic list_empty;
  logic free_in_range;
  logic no_slot;
  logic pop_start;
  logic rsp_load;

  assign out_free      = !rsp_valid || rsp_ready;
  assign req_ready     = !rst && (state == S_IDLE) && out_free;
  assign req_fire      = req_valid && req_ready;
  assign list_empty    = list_head >= hsa_pkg::TABLE_ENTRIES;
  assign free_in_range = {1'b0, req.slot_to_free} < hsa_pkg::TABLE_ENTRIES;
  assign no_slot       = (free_count == '0) ||
                         (list_empty && (bump_pointer >= hsa_pkg::TABLE_ENTRIES));
  assign link_we       = req_fire && (req.opcode == hsa_pkg::OP_FREE) && free_in_range;

  // an allocate served from the list waits in S_POP for the head link
  assign pop_start     = req_fire && (req.opcode == hsa_pkg::OP_ALLOC) &&
                         !no_slot && !list_empty;
  // every other transaction, and the S_POP state of a pop, loads a response
  assign rsp_load      = (state == S_POP) || (req_fire && !pop_start);

  // write on free, read of the current head every cycle; a pop uses the
  // data captured at its accept edge, which never coincides with a write
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[req.slot_to_free] <= list_head;
    end
    link_rd <= link_mem[list_head[hsa_pkg::SlotW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      list_head    <= hsa_pkg::TABLE_ENTRIES;
      bump_pointer <= '0;
      free_count   <= hsa_pkg::TABLE_ENTRIES;
      rsp_valid    <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            if (req.opcode == hsa_pkg::OP_FREE) begin
              // push onto the list head, count saturates at capacity
              if (free_in_range) begin
                list_head <= {1'b0, req.slot_to_free};
                if (free_count < hsa_pkg::TABLE_ENTRIES) begin
                  free_count   <= free_count + 1'b1;
                  rsp.free_slots <= free_count + 1'b1;
                end else begin
                  rsp.free_slots <= free_count;
                end
              end else begin
                rsp.free_slots <= free_count;
              end
              rsp.slot_given <= '0;
              rsp.status     <= hsa_pkg::ST_FREED;
              rsp.high_water <= bump_pointer;
            end else if (no_slot) begin
              rsp.slot_given <= '0;
              rsp.status     <= hsa_pkg::ST_FULL;
              rsp.high_water <= bump_pointer;
              rsp.free_slots <= free_count;
            end else if (list_empty) begin
              // fresh slot from the bump pointer
              bump_pointer   <= bump_pointer + 1'b1;
              free_count     <= free_count - 1'b1;
              rsp.slot_given <= bump_pointer[hsa_pkg::SlotW-1:0];
              rsp.status     <= hsa_pkg::ST_ALLOCATED;
              rsp.high_water <= bump_pointer + 1'b1;
              rsp.free_slots <= free_count - 1'b1;
            end else begin
              // head link is being read this edge
              state <= S_POP;
            end
          end
        end
        S_POP: begin
          list_head      <= link_rd;
          free_count     <= free_count - 1'b1;
          rsp.slot_given <= list_head[hsa_pkg::SlotW-1:0];
          rsp.status     <= hsa_pkg::ST_ALLOCATED;
          rsp.high_water <= bump_pointer;
          rsp.free_slots <= free_count - 1'b1;
          state          <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a pop only starts with the response register empty or draining
  a_pop_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) |-> !rsp_valid)
    else $error("pop cycle with a response still held");

  // a pop never starts on an empty list
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) |-> !list_empty && (free_count != '0))
    else $error("pop from empty list");

  // counters stay within capacity
  a_counts_bounded: assert property (@(posedge clk) disable iff (rst)
    (free_count <= hsa_pkg::TABLE_ENTRIES) && (bump_pointer <= hsa_pkg::TABLE_ENTRIES))
    else $error("free count or bump pointer beyond capacity");

  // a pop always completes in the following cycle
  a_pop_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) |=> (state == S_IDLE) && rsp_valid)
    else $error("pop did not complete");

endmodule

`default_nettype wire

// ----- tb/handle_slot_allocator_unit_tb.sv -----
// ----------------------------------------------------------------------------
// handle_slot_allocator_unit_tb
// self-checking bench for the slot allocator: a ledger class tracks the free
// list, bump pointer and free count, works out the reply to every accepted
// request and checks each response transaction in order against it
// ----------------------------------------------------------------------------

module handle_slot_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // ledger of the allocator: its own copy of the list, links and counters,
  // plus the replies still owed by the block in request order
  class allocator_ledger;
    logic [hsa_pkg::CountW-1:0] link_mem [hsa_pkg::TableEntries];
    logic [hsa_pkg::CountW-1:0] head;
    logic [hsa_pkg::CountW-1:0] bump;
    logic [hsa_pkg::CountW-1:0] free_cnt;
    hsa_pkg::rsp_t              replies_due [$];
    int unsigned                mismatches;

    function new();
      foreach (link_mem[i]) link_mem[i] = '0;
      head       = hsa_pkg::TABLE_ENTRIES;
      bump       = '0;
      free_cnt   = hsa_pkg::TABLE_ENTRIES;
      mismatches = 0;
    endfunction

    // apply one accepted request and queue the reply it must produce
    function hsa_pkg::rsp_t predict_reply(hsa_pkg::req_t item);
      hsa_pkg::rsp_t reply;
      logic list_empty;
      reply      = '0;
      list_empty = (head >= hsa_pkg::TABLE_ENTRIES);
      if (item.opcode == hsa_pkg::OP_FREE) begin
        reply.status = hsa_pkg::ST_FREED;
        if (hsa_pkg::CountW'(item.slot_to_free) < hsa_pkg::TABLE_ENTRIES) begin
          link_mem[item.slot_to_free] = head;
          head = hsa_pkg::CountW'(item.slot_to_free);
          if (free_cnt < hsa_pkg::TABLE_ENTRIES) free_cnt++;
        end
      end else if (free_cnt == '0 ||
                   (list_empty && bump >= hsa_pkg::TABLE_ENTRIES)) begin
        reply.status = hsa_pkg::ST_FULL;
      end else if (list_empty) begin
        reply.status     = hsa_pkg::ST_ALLOCATED;
        reply.slot_given = bump[hsa_pkg::SlotW-1:0];
        bump++;
        free_cnt--;
      end else begin
        reply.status     = hsa_pkg::ST_ALLOCATED;
        reply.slot_given = head[hsa_pkg::SlotW-1:0];
        head = link_mem[head[hsa_pkg::SlotW-1:0]];
        free_cnt--;
      end
      reply.high_water = bump;
      reply.free_slots = free_cnt;
      replies_due.push_back(reply);
      return reply;
    endfunction

    function void check_reply(hsa_pkg::rsp_t got);
      hsa_pkg::rsp_t want;
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected response: slot %0d status %0d high_water %0d free_slots %0d",
                   got.slot_given, got.status, got.high_water, got.free_slots);
        return;
      end
      want = replies_due.pop_front();
      if (got.slot_given !== want.slot_given || got.status !== want.status ||
          got.high_water !== want.high_water || got.free_slots !== want.free_slots) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected slot %0d status %0d high_water %0d free_slots %0d",
                   want.slot_given, want.status, want.high_water, want.free_slots);
          $display("          got      slot %0d status %0d high_water %0d free_slots %0d",
                   got.slot_given, got.status, got.high_water, got.free_slots);
        end
      end
    endfunction

    function int pending();
      return replies_due.size();
    endfunction
  endclass

  // receiver behaviour: streams, chops now and then, or stalls for long runs
  typedef enum {RX_STREAM, RX_CHOPPY, RX_SLUGGISH} rx_mode_t;
  // sender traffic mix of a burst
  typedef enum {TX_ALLOC_HEAVY, TX_FREE_HEAVY, TX_MIXED} tx_mix_t;

  localparam int RandomItems = 1020;

  logic           clk = 1'b0;
  logic           rst;
  logic           req_valid;
  logic           req_ready;
  hsa_pkg::req_t  req;
  logic           rsp_valid;
  logic           rsp_ready = 1'b0;
  hsa_pkg::rsp_t  rsp;

  allocator_ledger           ledger;
  logic [hsa_pkg::SlotW-1:0] held_slots [$];   // slots handed out and not yet returned
  rx_mode_t                  rx_mode = RX_STREAM;
  int unsigned               rx_left = 0;

  handle_slot_allocator_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // response side: stall pattern driven on the falling edge, every accepted
  // response transaction checked at the rising edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      rx_left = $urandom_range(16, 160);
    end
    rx_left--;
    case (rx_mode)
      RX_STREAM:   rsp_ready <= 1'b1;
      RX_CHOPPY:   rsp_ready <= ($urandom_range(0, 3) != 0);
      default:     rsp_ready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) ledger.check_reply(rsp);
  end

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // present one request and hold it until the block takes it; the ledger is
  // updated at the accepting edge, and granted slots join the held pool
  task automatic send_request(input hsa_pkg::req_t item);
    hsa_pkg::rsp_t due;
    @(negedge clk);
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!req_ready);
    due = ledger.predict_reply(item);
    if (item.opcode == hsa_pkg::OP_ALLOC && due.status == hsa_pkg::ST_ALLOCATED)
      held_slots.push_back(due.slot_given);
  endtask

  // slot_to_free is meaningless on an allocate, so it carries whatever is given
  task automatic request_alloc(input logic [hsa_pkg::SlotW-1:0] stray);
    hsa_pkg::req_t item;
    item.opcode       = hsa_pkg::OP_ALLOC;
    item.slot_to_free = stray;
    send_request(item);
  endtask

  task automatic request_free(input logic [hsa_pkg::SlotW-1:0] slot);
    hsa_pkg::req_t item;
    item.opcode       = hsa_pkg::OP_FREE;
    item.slot_to_free = slot;
    send_request(item);
  endtask

  // mostly a slot that is really held; otherwise any index, which gives
  // frees of never-allocated slots and double frees
  function automatic logic [hsa_pkg::SlotW-1:0] pick_free_target();
    int idx;
    logic [hsa_pkg::SlotW-1:0] slot;
    if (held_slots.size() != 0 && $urandom_range(0, 99) < 85) begin
      idx  = $urandom_range(0, held_slots.size() - 1);
      slot = held_slots[idx];
      held_slots.delete(idx);
    end else begin
      slot = hsa_pkg::SlotW'($urandom_range(0, hsa_pkg::TableEntries - 1));
    end
    return slot;
  endfunction

  task automatic sender_gap(input int unsigned cycles);
    if (cycles != 0) begin
      @(negedge clk);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // stop sending and let every owed response come back
  task automatic wait_for_all_results();
    @(negedge clk);
    req_valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned sent;
    int unsigned burst;
    int unsigned alloc_pct;
    tx_mix_t     mix;

    req_valid = 1'b0;
    req       = '0;
    rst       = 1'b1;
    ledger    = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: frees while every slot is already free (count saturates but
    // the slots still go on the list), pops of those, fresh bump slots,
    // frees of never-allocated slots, alternating bit patterns on the index
    request_free(12'hFFF);
    request_free(12'h000);
    request_alloc(12'hFFF);
    request_alloc(12'h000);
    request_alloc(12'hAAA);
    request_alloc(12'h555);
    request_alloc(12'h000);
    request_free(12'h001);
    request_free(12'hAAA);
    request_alloc(12'h123);
    request_alloc(12'hFFF);
    request_alloc(12'h000);
    request_free(12'h555);
    request_free(12'h002);
    request_alloc(12'hAAA);
    request_alloc(12'h555);
    request_alloc(12'hFFF);
    wait_for_all_results();

    // a slot freed twice in a row links to itself, so the following pops
    // keep returning it
    request_free(12'h007);
    request_free(12'h007);
    request_alloc(12'h000);
    request_alloc(12'h000);
    request_alloc(12'h000);
    request_alloc(12'h000);
    wait_for_all_results();

    // random traffic: bursts biased toward allocates or frees so the count
    // swings up and down, gaps between bursts, and now and then a full drain
    sent = 0;
    while (sent < RandomItems) begin
      burst = $urandom_range(1, 40);
      mix   = tx_mix_t'($urandom_range(0, 2));
      case (mix)
        TX_ALLOC_HEAVY: alloc_pct = 80;
        TX_FREE_HEAVY:  alloc_pct = 20;
        default:        alloc_pct = 50;
      endcase
      repeat (burst) begin
        if ($urandom_range(0, 99) < alloc_pct) request_alloc(hsa_pkg::SlotW'($urandom));
        else request_free(pick_free_target());
      end
      sent += burst;
      if ($urandom_range(0, 19) == 0) wait_for_all_results();
      else if ($urandom_range(0, 2) != 0) sender_gap($urandom_range(1, 8));
    end

    wait_for_all_results();
    repeat (20) @(posedge clk);
    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
